[hw/rtl/sbcd_pkg.sv]
package sbcd_pkg;

	localparam int FRAME_LENGTH_DEF  = 25;
	localparam int FRACTION_BITS_DEF = 16;

	localparam int BYTE_W   = 8;
	localparam int CHAN_W   = 3;
	localparam int RAW_W    = 11;
	localparam int NORM_W   = 19;
	localparam int REG_W    = 3 * RAW_W;
	localparam int CFG_IDX_W = 2;

	localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'h0f;
	localparam int KEPT_BYTES = 10;

	// byte counts at which a channel completes
	localparam int CNT_CH0 = 3;
	localparam int CNT_CH1 = 4;
	localparam int CNT_CH2 = 6;
	localparam int CNT_CH3 = 7;
	localparam int CNT_CH4 = 8;
	localparam int CNT_CH5 = 10;

	localparam logic [CHAN_W-1:0] CH0 = 3'd0;
	localparam logic [CHAN_W-1:0] CH1 = 3'd1;
	localparam logic [CHAN_W-1:0] CH2 = 3'd2;
	localparam logic [CHAN_W-1:0] CH3 = 3'd3;
	localparam logic [CHAN_W-1:0] CH4 = 3'd4;
	localparam logic [CHAN_W-1:0] CH5 = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_LO_FIRST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LO_SECOND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HI_FIRST  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HI_SECOND = 2'd3;

	localparam logic [REG_W-1:0] LO_FIRST_RST  = 33'd1355424076;
	localparam logic [REG_W-1:0] LO_SECOND_RST = 33'd604275028;
	localparam logic [REG_W-1:0] HI_FIRST_RST  = 33'd7234504404;
	localparam logic [REG_W-1:0] HI_SECOND_RST = 33'd7989855923;

	localparam logic signed [NORM_W-1:0] NORM_MAX = 19'sd262143;
	localparam logic signed [NORM_W-1:0] NORM_MIN = -19'sd262144;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [CHAN_W-1:0] chan;
		logic [RAW_W-1:0]  raw;
		logic [RAW_W-1:0]  lo;
		logic [RAW_W-1:0]  hi;
	} qent_t;

	typedef struct packed {
		logic  push;
		qent_t ent;
	} qwr_t;

endpackage

[hw/rtl/sbcd_front.sv]
module sbcd_front
	import sbcd_pkg::*;
#(
	parameter int FRAME_LENGTH = FRAME_LENGTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic                 full,
	input  logic [BYTE_W-1:0]    rx_byte,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data,
	output qwr_t                 q_wr
);

	localparam int POS_W = $clog2(FRAME_LENGTH);
	localparam int CNT_W = POS_W + 1;

	logic [POS_W-1:0]  pos_q;
	logic [BYTE_W-1:0] frame_q [1:KEPT_BYTES-1];
	logic [REG_W-1:0]  lo_first_q, lo_second_q, hi_first_q, hi_second_q;

	logic [BYTE_W-1:0] w [1:KEPT_BYTES-1];
	logic [CNT_W-1:0]  count;
	logic              accept;
	logic              hit;
	logic [CHAN_W-1:0] chan;
	logic [RAW_W-1:0]  raw, lo, hi;
	logic [POS_W-1:0]  pos_nx;

	assign accept = push && !full;

	always_comb begin
		// newest byte is seen before it lands in the frame store
		for (int i = 1; i < KEPT_BYTES; i++) begin
			w[i] = (pos_q == POS_W'(i)) ? rx_byte : frame_q[i];
		end
		count = CNT_W'(pos_q) + CNT_W'(1);
		hit   = 1'b0;
		chan  = CH0;
		raw   = '0;
		lo    = '0;
		hi    = '0;
		unique case (count)
			CNT_W'(CNT_CH0): begin
				hit  = 1'b1;
				chan = CH0;
				raw  = {w[2][2:0], w[1]};
				lo   = lo_first_q[RAW_W-1:0];
				hi   = hi_first_q[RAW_W-1:0];
			end
			CNT_W'(CNT_CH1): begin
				hit  = 1'b1;
				chan = CH1;
				raw  = {w[3][5:0], w[2][7:3]};
				lo   = lo_first_q[2*RAW_W-1:RAW_W];
				hi   = hi_first_q[2*RAW_W-1:RAW_W];
			end
			CNT_W'(CNT_CH2): begin
				hit  = 1'b1;
				chan = CH2;
				raw  = {w[5][0], w[4], w[3][7:6]};
				lo   = lo_first_q[3*RAW_W-1:2*RAW_W];
				hi   = hi_first_q[3*RAW_W-1:2*RAW_W];
			end
			CNT_W'(CNT_CH3): begin
				hit  = 1'b1;
				chan = CH3;
				raw  = {w[6][3:0], w[5][7:1]};
				lo   = lo_second_q[RAW_W-1:0];
				hi   = hi_second_q[RAW_W-1:0];
			end
			CNT_W'(CNT_CH4): begin
				hit  = 1'b1;
				chan = CH4;
				raw  = {w[7][6:0], w[6][7:4]};
				lo   = lo_second_q[2*RAW_W-1:RAW_W];
				hi   = hi_second_q[2*RAW_W-1:RAW_W];
			end
			CNT_W'(CNT_CH5): begin
				hit  = 1'b1;
				chan = CH5;
				raw  = {w[9][1:0], w[8], w[7][7]};
				lo   = lo_second_q[3*RAW_W-1:2*RAW_W];
				hi   = hi_second_q[3*RAW_W-1:2*RAW_W];
			end
			default: begin
				hit = 1'b0;
			end
		endcase
		pos_nx = (count >= CNT_W'(FRAME_LENGTH)) ? '0 : count[POS_W-1:0];
	end

	assign q_wr.push     = accept && hit;
	assign q_wr.ent.chan = chan;
	assign q_wr.ent.raw  = raw;
	assign q_wr.ent.lo   = lo;
	assign q_wr.ent.hi   = hi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			lo_first_q  <= LO_FIRST_RST;
			lo_second_q <= LO_SECOND_RST;
			hi_first_q  <= HI_FIRST_RST;
			hi_second_q <= HI_SECOND_RST;
		end else begin
			// idle: only the header opens a frame
			if (accept && (pos_q != '0 || rx_byte == HEADER_BYTE)) begin
				pos_q <= pos_nx;
			end
			if (cfg_write) begin
				case (cfg_index)
					REG_LO_FIRST:  lo_first_q  <= cfg_data;
					REG_LO_SECOND: lo_second_q <= cfg_data;
					REG_HI_FIRST:  hi_first_q  <= cfg_data;
					REG_HI_SECOND: hi_second_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 1; i < KEPT_BYTES; i++) begin
			if (accept && pos_q == POS_W'(i)) begin
				frame_q[i] <= rx_byte;
			end
		end
	end

endmodule

[hw/rtl/sbcd_queue.sv]
module sbcd_queue
	import sbcd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  qwr_t  q_wr,
	input  logic  q_pop,
	output logic  q_full,
	output logic  q_empty,
	output qent_t q_data
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	qent_t            ent_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr, do_rd;

	assign q_full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign q_empty = (cnt_q == '0);
	assign q_data  = ent_q[rd_ptr_q];
	assign do_wr   = q_wr.push && !q_full;
	assign do_rd   = q_pop && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			ent_q[wr_ptr_q] <= q_wr.ent;
		end
	end

endmodule

[hw/rtl/sbcd_back.sv]
module sbcd_back
	import sbcd_pkg::*;
#(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_empty,
	input  qent_t                    q_data,
	output logic                     q_pop,
	input  logic                     pop,
	output logic                     empty,
	output logic [CHAN_W-1:0]        channel_index,
	output logic [RAW_W-1:0]         raw_value,
	output logic signed [NORM_W-1:0] normalized_value
);

	localparam int DIV_W  = RAW_W + FRACTION_BITS;
	localparam int STEP_W = $clog2(DIV_W + 1);
	localparam int DIF_W  = RAW_W + 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]               state_q;
	logic [STEP_W-1:0]        cnt_q;
	logic [RAW_W-1:0]         rem_q, dmag_q;
	logic [DIV_W-1:0]         dq_q;
	logic                     neg_q, zs_q;
	logic signed [NORM_W-1:0] res_q;
	logic [CHAN_W-1:0]        chan_q;
	logic [RAW_W-1:0]         raw_q;

	logic                     out_valid_q;
	logic [CHAN_W-1:0]        out_chan_q;
	logic [RAW_W-1:0]         out_raw_q;
	logic signed [NORM_W-1:0] out_norm_q;

	logic signed [DIF_W-1:0]  num, span;
	logic [DIF_W-1:0]         num_abs, span_abs;
	logic signed [NORM_W-1:0] zs_val;
	logic [DIF_W-1:0]         trial, diff;
	logic                     ge;
	logic                     ovf;
	logic [NORM_W-1:0]        mag;
	logic signed [NORM_W-1:0] sat, final_val;
	logic                     fin_go;

	always_comb begin
		num      = DIF_W'(q_data.raw) - DIF_W'(q_data.lo);
		span     = DIF_W'(q_data.hi) - DIF_W'(q_data.lo);
		num_abs  = num[DIF_W-1] ? DIF_W'(-num) : DIF_W'(num);
		span_abs = span[DIF_W-1] ? DIF_W'(-span) : DIF_W'(span);
		if (num == '0) begin
			zs_val = '0;
		end else if (num[DIF_W-1]) begin
			zs_val = NORM_MIN;
		end else begin
			zs_val = NORM_MAX;
		end

		// restoring step: remainder stays below the divisor
		trial = {rem_q, dq_q[DIV_W-1]};
		diff  = trial - {1'b0, dmag_q};
		ge    = (trial >= {1'b0, dmag_q});

		ovf = |dq_q[DIV_W-1:NORM_W-1];
		mag = dq_q[NORM_W-1:0];
		if (neg_q) begin
			sat = ovf ? NORM_MIN : -$signed(mag);
		end else begin
			sat = ovf ? NORM_MAX : $signed(mag);
		end
		final_val = zs_q ? res_q : sat;
	end

	assign q_pop  = (state_q == ST_IDLE) && !q_empty;
	assign fin_go = (state_q == ST_FIN) && (!out_valid_q || pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						state_q <= (span == '0) ? ST_FIN : ST_DIV;
					end
				end
				ST_DIV: begin
					if (cnt_q == STEP_W'(1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			chan_q <= q_data.chan;
			raw_q  <= q_data.raw;
			zs_q   <= (span == '0);
			res_q  <= zs_val;
			neg_q  <= num[DIF_W-1] ^ span[DIF_W-1];
			dmag_q <= span_abs[RAW_W-1:0];
			rem_q  <= '0;
			dq_q   <= {num_abs[RAW_W-1:0], FRACTION_BITS'(0)};
			cnt_q  <= STEP_W'(DIV_W);
		end else if (state_q == ST_DIV) begin
			rem_q <= ge ? diff[RAW_W-1:0] : trial[RAW_W-1:0];
			dq_q  <= {dq_q[DIV_W-2:0], ge};
			cnt_q <= cnt_q - STEP_W'(1);
		end
		if (fin_go) begin
			out_chan_q <= chan_q;
			out_raw_q  <= raw_q;
			out_norm_q <= final_val;
		end
	end

	assign empty            = !out_valid_q;
	assign channel_index    = out_chan_q;
	assign raw_value        = out_raw_q;
	assign normalized_value = out_norm_q;

endmodule

[hw/rtl/sbus_channel_decoder_top.sv]
// Channel    | Handshake          | Payload
// -----------+--------------------+------------------------------------------
// byte in    | push / full        | rx_byte
// result out | empty / pop        | channel_index, raw_value, normalized_value
// config     | cfg_write          | cfg_index, cfg_data
//
// A byte that completes no channel is taken while full is low.
// Each result passes through the one-bit-per-cycle restoring divider,
// except with a zero span, which skips the divider.
// A two-entry request queue feeds the divider; full holds off every byte while it holds two.
// The result register frees the divider while a result waits for pop.
// Reset clears the byte count, presets bounds; the frame store is written before read.
module sbus_channel_decoder_top
	import sbcd_pkg::*;
#(
	parameter int FRAME_LENGTH  = FRAME_LENGTH_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic [BYTE_W-1:0]        rx_byte,
	output logic                     empty,
	input  logic                     pop,
	output logic [CHAN_W-1:0]        channel_index,
	output logic [RAW_W-1:0]         raw_value,
	output logic signed [NORM_W-1:0] normalized_value,
	input  logic                     cfg_write,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [REG_W-1:0]         cfg_data
);

	qwr_t  q_wr;
	logic  q_full, q_empty, q_pop;
	qent_t q_data;

	assign full = q_full;

	sbcd_front #(
		.FRAME_LENGTH(FRAME_LENGTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (q_full),
		.rx_byte  (rx_byte),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.q_wr     (q_wr)
	);

	sbcd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.q_pop  (q_pop),
		.q_full (q_full),
		.q_empty(q_empty),
		.q_data (q_data)
	);

	sbcd_back #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_empty         (q_empty),
		.q_data          (q_data),
		.q_pop           (q_pop),
		.pop             (pop),
		.empty           (empty),
		.channel_index   (channel_index),
		.raw_value       (raw_value),
		.normalized_value(normalized_value)
	);

`ifndef SYNTHESIS
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_wr.push && q_full))
		else $error("request pushed into a full queue");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && q_empty))
		else $error("request taken from an empty queue");

	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (channel_index <= CH5))
		else $error("result carries a channel index beyond five");

	a_push_needs_accept: assert property (@(posedge clk) disable iff (!arst_n)
		q_wr.push |-> (push && !full))
		else $error("request queued without an accepted byte");
`endif

endmodule

[tb/sv/sbcd_checker.sv]
`timescale 1ns / 1ps

module sbcd_checker
	import sbcd_pkg::*;
#(
	parameter int FRAME_LENGTH  = FRAME_LENGTH_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  logic                     full,
	input  logic [BYTE_W-1:0]        rx_byte,
	input  logic                     empty,
	input  logic                     pop,
	input  logic [CHAN_W-1:0]        channel_index,
	input  logic [RAW_W-1:0]         raw_value,
	input  logic signed [NORM_W-1:0] normalized_value,
	input  logic                     cfg_write,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [REG_W-1:0]         cfg_data,
	output int                       pending_results,
	output int                       mismatches,
	output int                       results_checked
);

	typedef struct {
		logic [CHAN_W-1:0]        chan;
		logic [RAW_W-1:0]         raw;
		logic signed [NORM_W-1:0] norm;
	} chan_result_t;

	chan_result_t      expected_channels[$];
	logic [REG_W-1:0]  bound_regs [0:3];
	logic [4:0]        frame_count;
	logic [BYTE_W-1:0] frame_store [0:KEPT_BYTES-1];
	int                fail_total;
	int                checked_total;

	assign mismatches      = fail_total;
	assign results_checked = checked_total;

	task automatic report_mismatch(input string msg);
		fail_total++;
		$display("[%0t] MISMATCH %s", $time, msg);
	endtask

	// (raw - lo) / (hi - lo) in signed fixed point, truncated, then clamped
	function automatic logic signed [NORM_W-1:0] scale_channel(
		logic [RAW_W-1:0] raw, logic [RAW_W-1:0] lo, logic [RAW_W-1:0] hi);
		longint num, span, nmag, dmag, q;
		num  = longint'(raw) - longint'(lo);
		span = longint'(hi) - longint'(lo);
		if (span == 0) begin
			if (num > 0)
				return NORM_MAX;
			if (num < 0)
				return NORM_MIN;
			return '0;
		end
		nmag = (num < 0 ? -num : num) << FRACTION_BITS;
		dmag = span < 0 ? -span : span;
		q    = nmag / dmag;
		if ((num < 0) != (span < 0)) begin
			if (-q < longint'(NORM_MIN))
				return NORM_MIN;
			return NORM_W'(-q);
		end
		if (q > longint'(NORM_MAX))
			return NORM_MAX;
		return NORM_W'(q);
	endfunction

	always @(posedge clk or negedge arst_n) begin : predict_and_check
		logic [5:0]       count;
		int unsigned      word;
		int               chan;
		int               slot;
		logic [REG_W-1:0] lo_reg, hi_reg;
		logic [RAW_W-1:0] raw;
		chan_result_t     want;
		if (!arst_n) begin
			bound_regs[REG_LO_FIRST]  = LO_FIRST_RST;
			bound_regs[REG_LO_SECOND] = LO_SECOND_RST;
			bound_regs[REG_HI_FIRST]  = HI_FIRST_RST;
			bound_regs[REG_HI_SECOND] = HI_SECOND_RST;
			frame_count = '0;
			expected_channels.delete();
			fail_total    = 0;
			checked_total = 0;
			pending_results <= 0;
		end else begin
			if (cfg_write)
				bound_regs[cfg_index] = cfg_data;

			if (pop && !empty) begin
				checked_total++;
				if (expected_channels.size() == 0) begin
					report_mismatch($sformatf("unexpected result: ch %0d raw %0d norm %0d",
						channel_index, raw_value, normalized_value));
				end else begin
					want = expected_channels.pop_front();
					if (channel_index !== want.chan)
						report_mismatch($sformatf("channel_index: got %0d, want %0d",
							channel_index, want.chan));
					if (raw_value !== want.raw)
						report_mismatch($sformatf("raw_value ch %0d: got %0d, want %0d",
							want.chan, raw_value, want.raw));
					if (normalized_value !== want.norm)
						report_mismatch($sformatf("normalized_value ch %0d: got %0d, want %0d",
							want.chan, normalized_value, want.norm));
				end
			end

			if (push && !full) begin
				count = '0;
				if (frame_count == 0) begin
					if (rx_byte == HEADER_BYTE) begin
						frame_store[0] = rx_byte;
						count = 6'd1;
					end
				end else begin
					if (frame_count < KEPT_BYTES)
						frame_store[frame_count] = rx_byte;
					count = frame_count + 6'd1;
				end

				chan = -1;
				word = 0;
				case (count)
					CNT_CH0: begin
						chan = CH0;
						word = frame_store[1] | (frame_store[2] << 8);
					end
					CNT_CH1: begin
						chan = CH1;
						word = (frame_store[2] >> 3) | (frame_store[3] << 5);
					end
					CNT_CH2: begin
						chan = CH2;
						word = (frame_store[3] >> 6) | (frame_store[4] << 2)
							| (frame_store[5] << 10);
					end
					CNT_CH3: begin
						chan = CH3;
						word = (frame_store[5] >> 1) | (frame_store[6] << 7);
					end
					CNT_CH4: begin
						chan = CH4;
						word = (frame_store[6] >> 4) | (frame_store[7] << 4);
					end
					CNT_CH5: begin
						chan = CH5;
						word = (frame_store[7] >> 7) | (frame_store[8] << 1)
							| (frame_store[9] << 9);
					end
					default: ;
				endcase

				if (chan >= 0) begin
					slot   = chan % 3;
					lo_reg = (chan < 3) ? bound_regs[REG_LO_FIRST] : bound_regs[REG_LO_SECOND];
					hi_reg = (chan < 3) ? bound_regs[REG_HI_FIRST] : bound_regs[REG_HI_SECOND];
					raw    = word[RAW_W-1:0];
					want.chan = CHAN_W'(chan);
					want.raw  = raw;
					want.norm = scale_channel(raw, lo_reg[slot*RAW_W +: RAW_W],
						hi_reg[slot*RAW_W +: RAW_W]);
					expected_channels.push_back(want);
				end

				frame_count = (count >= FRAME_LENGTH) ? 5'd0 : count[4:0];
			end

			pending_results <= expected_channels.size();
		end
	end

endmodule

[tb/sv/tb_sbus_channel_decoder_top.sv]
`timescale 1ns / 1ps

module tb_sbus_channel_decoder_top
	import sbcd_pkg::*;
();

	localparam int CLK_PERIOD    = 10;
	localparam int NUM_PHASES    = 7;
	localparam int FRAMES_EACH   = 3;
	localparam int SETTLE_CYCLES = 80;
	localparam int RUN_LIMIT_NS  = 3_000_000;

	logic                     clk;
	logic                     arst_n;
	logic                     push;
	logic                     full;
	logic [BYTE_W-1:0]        rx_byte;
	logic                     empty;
	logic                     pop;
	logic [CHAN_W-1:0]        channel_index;
	logic [RAW_W-1:0]         raw_value;
	logic signed [NORM_W-1:0] normalized_value;
	logic                     cfg_write;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [REG_W-1:0]         cfg_data;

	int pending_results;
	int mismatches;
	int results_checked;

	bit               idle_en;
	int               stim_pos;
	int               frames_sent;
	logic [REG_W-1:0] bounds_now [0:3];

	sbus_channel_decoder_top dut (.*);

	sbcd_checker u_checker (.*);

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	initial begin
		#(RUN_LIMIT_NS);
		$display("Test completed with failures");
		$finish;
	end

	// tracks frame alignment so that shaped frames start from idle
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		if (idle_en && $urandom_range(0, 15) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		push    <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (full)
			@(posedge clk);
		if (stim_pos == 0)
			stim_pos = (b == HEADER_BYTE) ? 1 : 0;
		else
			stim_pos = (stim_pos + 1 >= FRAME_LENGTH_DEF) ? 0 : stim_pos + 1;
	endtask

	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	task automatic write_settings();
		put_reg(REG_LO_FIRST,  bounds_now[REG_LO_FIRST]);
		put_reg(REG_LO_SECOND, bounds_now[REG_LO_SECOND]);
		put_reg(REG_HI_FIRST,  bounds_now[REG_HI_FIRST]);
		put_reg(REG_HI_SECOND, bounds_now[REG_HI_SECOND]);
		cfg_write <= 1'b0;
	endtask

	// bytes 1..9 carry the packed channels, the tail is random
	task automatic send_stream(input logic [71:0] stream);
		while (stim_pos != 0)
			send_byte(BYTE_W'($urandom));
		send_byte(HEADER_BYTE);
		for (int i = 0; i < 9; i++)
			send_byte(stream[i*8 +: 8]);
		for (int i = 10; i < FRAME_LENGTH_DEF; i++)
			send_byte(BYTE_W'($urandom));
		frames_sent++;
	endtask

	function automatic logic [RAW_W-1:0] pick_raw(logic [RAW_W-1:0] lo, logic [RAW_W-1:0] hi);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return lo;
			3: return hi;
			4: return lo + 1'b1;
			5: return lo - 1'b1;
			6: return hi + 1'b1;
			7: return hi - 1'b1;
			default: return RAW_W'($urandom);
		endcase
	endfunction

	function automatic logic [REG_W-1:0] pack_bounds(
		int unsigned a, int unsigned b, int unsigned c);
		return {RAW_W'(c), RAW_W'(b), RAW_W'(a)};
	endfunction

	task automatic send_random_frame(input bit shaped);
		logic [71:0]      stream;
		logic [RAW_W-1:0] lo, hi;
		stream = 72'({$urandom, $urandom, $urandom});
		if (shaped) begin
			for (int ch = 0; ch < 6; ch++) begin
				lo = bounds_now[ch < 3 ? REG_LO_FIRST : REG_LO_SECOND][(ch % 3)*RAW_W +: RAW_W];
				hi = bounds_now[ch < 3 ? REG_HI_FIRST : REG_HI_SECOND][(ch % 3)*RAW_W +: RAW_W];
				stream[ch*RAW_W +: RAW_W] = pick_raw(lo, hi);
			end
		end
		send_stream(stream);
	endtask

	initial begin
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (idle_en && $urandom_range(0, 11) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else begin
				pop <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		logic [BYTE_W-1:0] noise;
		arst_n    <= 1'b0;
		push      <= 1'b0;
		rx_byte   <= '0;
		cfg_write <= 1'b0;
		cfg_index <= REG_LO_FIRST;
		cfg_data  <= '0;
		idle_en     = 1'b1;
		stim_pos    = 0;
		frames_sent = 0;
		bounds_now[REG_LO_FIRST]  = LO_FIRST_RST;
		bounds_now[REG_LO_SECOND] = LO_SECOND_RST;
		bounds_now[REG_HI_FIRST]  = HI_FIRST_RST;
		bounds_now[REG_HI_SECOND] = HI_SECOND_RST;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle noise, then a frame with a header value in byte 1, all-zero and
		// all-one bytes, channels at 0 and full scale, at a minimum and a maximum
		send_byte(8'h00);
		send_byte(8'hff);
		send_stream({6'h3f, 11'h7ff, LO_SECOND_RST[RAW_W +: RAW_W],
			HI_SECOND_RST[RAW_W-1:0], 11'h000, 11'h7ff, 11'(HEADER_BYTE)});

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph > 0) begin
				drain();
				case (ph)
					1: begin
						bounds_now[REG_LO_FIRST]  = '0;
						bounds_now[REG_LO_SECOND] = '0;
						bounds_now[REG_HI_FIRST]  = '1;
						bounds_now[REG_HI_SECOND] = '1;
					end
					2: begin
						bounds_now[REG_LO_FIRST]  = '1;
						bounds_now[REG_LO_SECOND] = '1;
						bounds_now[REG_HI_FIRST]  = '1;
						bounds_now[REG_HI_SECOND] = '1;
					end
					3: begin
						bounds_now[REG_LO_FIRST]  = '0;
						bounds_now[REG_LO_SECOND] = '0;
						bounds_now[REG_HI_FIRST]  = '0;
						bounds_now[REG_HI_SECOND] = '0;
					end
					4: begin
						// inverted spans: every minimum above its maximum
						bounds_now[REG_LO_FIRST] = pack_bounds($urandom_range(1024, 2047),
							$urandom_range(1024, 2047), $urandom_range(1024, 2047));
						bounds_now[REG_LO_SECOND] = pack_bounds($urandom_range(1024, 2047),
							$urandom_range(1024, 2047), $urandom_range(1024, 2047));
						bounds_now[REG_HI_FIRST] = pack_bounds($urandom_range(0, 1023),
							$urandom_range(0, 1023), $urandom_range(0, 1023));
						bounds_now[REG_HI_SECOND] = pack_bounds($urandom_range(0, 1023),
							$urandom_range(0, 1023), $urandom_range(0, 1023));
					end
					5: begin
						bounds_now[REG_LO_FIRST]  = REG_W'({$urandom, $urandom});
						bounds_now[REG_LO_SECOND] = REG_W'({$urandom, $urandom});
						bounds_now[REG_HI_FIRST]  = bounds_now[REG_LO_FIRST];
						bounds_now[REG_HI_SECOND] = bounds_now[REG_LO_SECOND];
					end
					default: begin
						bounds_now[REG_LO_FIRST]  = REG_W'({$urandom, $urandom});
						bounds_now[REG_LO_SECOND] = REG_W'({$urandom, $urandom});
						bounds_now[REG_HI_FIRST]  = REG_W'({$urandom, $urandom});
						bounds_now[REG_HI_SECOND] = REG_W'({$urandom, $urandom});
					end
				endcase
				write_settings();
			end
			idle_en = (ph < NUM_PHASES - 1);

			for (int f = 0; f < FRAMES_EACH; f++) begin
				if (ph == 1 && f == 2)
					drain();
				repeat ($urandom_range(0, 3)) begin
					noise = BYTE_W'($urandom);
					if (stim_pos == 0 && noise == HEADER_BYTE)
						noise = ~noise;
					send_byte(noise);
				end
				// unshaped bursts may start frames at odd places
				if ($urandom_range(0, 4) == 0)
					repeat ($urandom_range(1, 30)) send_byte(BYTE_W'($urandom));
				send_random_frame($urandom_range(0, 3) != 0);
			end
		end

		drain();
		$display("Covered %0d aligned frames plus noise over %0d bound settings",
			frames_sent, NUM_PHASES);
		$display("(reset, full scale, zero and inverted spans, random); %0d results checked",
			results_checked);
		if (mismatches == 0 && pending_results == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

[sbus_channel_decoder_top.f]
hw/rtl/sbcd_pkg.sv
hw/rtl/sbcd_front.sv
hw/rtl/sbcd_queue.sv
hw/rtl/sbcd_back.sv
hw/rtl/sbus_channel_decoder_top.sv
tb/sv/sbcd_checker.sv
tb/sv/tb_sbus_channel_decoder_top.sv
